// File: hw/rtl/tmf_pkg.sv
// Shared constants and control types of the trimmed-mean ADC fault filter.
`timescale 1ns / 1ps

package tmf_pkg;

    localparam int CHANNELS_DEF = 4;
    localparam int WINDOW       = 10;
    localparam int SAMPLE_W     = 12;
    localparam int CHAN_W       = 2;
    localparam int CNT_W        = 4;
    localparam int SUM_W        = SAMPLE_W + 2;
    localparam int TRIM_LO      = 3;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 16;
    localparam int CFG_IDX_W    = 2;

    localparam logic [SAMPLE_W-1:0]  OPEN_RESET    = 12'd50;
    localparam logic [SAMPLE_W-1:0]  SHORT_RESET   = 12'd4000;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_THR = 2'd1;
    localparam logic [CNT_W-1:0]     LAST_POS      = 4'd9;

    typedef struct packed {
        logic             write_smp;
        logic             rd_en;
        logic [CNT_W-1:0] rd_idx;
        logic             capture;
        logic             sort_en;
        logic             sort_odd;
        logic             load_out;
    } tmf_cmd_t;

    typedef struct packed {
        logic win_done;
    } tmf_sts_t;

endpackage

// File: hw/rtl/trimmed_mean_adc_fault_filter_core.sv
// Top level of the trimmed-mean ADC fault filter.
`timescale 1ns / 1ps

// Usage:
//   s_ channel carries one ADC sample per beat, tagged with its sensor channel.
//   Channels at or above CHANNELS are accepted and dropped. Each channel gathers
//   ten samples; the tenth sample of a window produces one m_ beat carrying the
//   mean of sorted samples three to six and that channel's sticky open/short
//   flags. Other samples produce no beat.
//   A sample that does not close a window is stored and s_tready stays high.
//   A closing sample starts 10 store reads (one read port), 10 odd-even
//   transposition phases and a result load, after which m_tvalid is high and
//   s_tready returns.
//   The result sits in an output register; new samples are taken while it waits.
//   If the receiver stalls and another window completes, the block holds that
//   result and s_tready stays low until the pending beat is taken.
//   Reset clears fill counts and flags and loads the thresholds (50 and 4000). The user must
//   write thresholds via cfg_we/cfg_index/cfg_wdata only while idle; the block does not check.
module trimmed_mean_adc_fault_filter_core #(
    parameter int CHANNELS = tmf_pkg::CHANNELS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tmf_pkg::IN_TDATA_W-1:0]  s_tdata,  // channel[1:0], sample[13:2], zero[15:14]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tmf_pkg::OUT_TDATA_W-1:0] m_tdata,  // out_channel[1:0], filtered[13:2],
                                                      // open_fault[14], short_fault[15]
    input  logic                            cfg_we,
    input  logic [tmf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tmf_pkg::SAMPLE_W-1:0]    cfg_wdata
);

    tmf_pkg::tmf_cmd_t cmd;
    tmf_pkg::tmf_sts_t sts;

    tmf_datapath #(
        .CHANNELS(CHANNELS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .cmd      (cmd),
        .sts      (sts)
    );

    tmf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

endmodule

// File: hw/rtl/tmf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module tmf_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 40
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/tmf_datapath.sv
// Datapath: sample store, fill counts, sort network registers, mean, fault flags.
`timescale 1ns / 1ps

module tmf_datapath #(
    parameter int CHANNELS = tmf_pkg::CHANNELS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [tmf_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic [tmf_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                cfg_we,
    input  logic [tmf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tmf_pkg::SAMPLE_W-1:0]        cfg_wdata,
    input  tmf_pkg::tmf_cmd_t                   cmd,
    output tmf_pkg::tmf_sts_t                   sts
);

    localparam int DEPTH = CHANNELS * tmf_pkg::WINDOW;
    localparam int AW    = $clog2(DEPTH);
    localparam int CIW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW    = tmf_pkg::SAMPLE_W;
    localparam int CW    = tmf_pkg::CNT_W;

    logic [tmf_pkg::CHAN_W-1:0] in_chan;
    logic [SW-1:0]              in_smp;
    logic                       chan_ok;
    logic [CIW-1:0]             in_idx;
    logic [CW-1:0]              fill_cur;
    logic [CW-1:0]              wr_pos;
    logic [AW-1:0]              wr_addr;
    logic [AW-1:0]              rd_addr;
    logic [SW-1:0]              rd_data;
    logic                       wr_en;

    logic [CW-1:0]  fill_reg [CHANNELS];
    logic           open_reg [CHANNELS];
    logic           short_reg [CHANNELS];
    logic [CIW-1:0] chan_reg;
    logic [SW-1:0]  open_thr_reg;
    logic [SW-1:0]  short_thr_reg;

    logic [SW-1:0] win_reg  [tmf_pkg::WINDOW];
    logic [SW-1:0] win_next [tmf_pkg::WINDOW];

    logic [tmf_pkg::SUM_W-1:0] sum;
    logic [SW-1:0]             mean;
    logic                      open_cur;
    logic                      short_cur;
    logic                      open_next;
    logic                      short_next;

    logic [tmf_pkg::CHAN_W-1:0] out_chan_reg;
    logic [SW-1:0]              filt_reg;
    logic                       out_open_reg;
    logic                       out_short_reg;

    assign in_chan  = s_tdata[tmf_pkg::CHAN_W-1:0];
    assign in_smp   = s_tdata[tmf_pkg::CHAN_W +: SW];
    assign chan_ok  = int'(in_chan) < CHANNELS;
    assign in_idx   = CIW'(in_chan);
    assign fill_cur = chan_ok ? fill_reg[in_idx] : '0;
    assign wr_pos   = (fill_cur > tmf_pkg::LAST_POS) ? '0 : fill_cur;
    assign wr_en    = cmd.write_smp && chan_ok;

    // channel * 10 as (channel << 3) + (channel << 1)
    assign wr_addr = AW'({in_idx, 3'b000}) + AW'({in_idx, 1'b0}) + AW'(wr_pos);
    assign rd_addr = AW'({chan_reg, 3'b000}) + AW'({chan_reg, 1'b0}) + AW'(cmd.rd_idx);

    assign sts.win_done = chan_ok && (wr_pos == tmf_pkg::LAST_POS);

    tmf_ram #(
        .WIDTH(SW),
        .DEPTH(DEPTH)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(in_smp),
        .rd_en  (cmd.rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // Odd-even transposition step, or shift in a word read from the store.
    always_comb begin
        for (int i = 0; i < tmf_pkg::WINDOW; i++) begin
            win_next[i] = win_reg[i];
        end
        if (cmd.capture) begin
            for (int i = 0; i < tmf_pkg::WINDOW - 1; i++) begin
                win_next[i] = win_reg[i+1];
            end
            win_next[tmf_pkg::WINDOW-1] = rd_data;
        end else if (cmd.sort_en) begin
            for (int i = 0; i < tmf_pkg::WINDOW - 1; i++) begin
                if ((i % 2 == 1) == cmd.sort_odd) begin
                    if (win_reg[i] > win_reg[i+1]) begin
                        win_next[i]   = win_reg[i+1];
                        win_next[i+1] = win_reg[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < tmf_pkg::WINDOW; i++) begin
            win_reg[i] <= win_next[i];
        end
        if (cmd.write_smp) begin
            chan_reg <= in_idx;
        end
    end

    assign sum = tmf_pkg::SUM_W'(win_reg[tmf_pkg::TRIM_LO])
               + tmf_pkg::SUM_W'(win_reg[tmf_pkg::TRIM_LO+1])
               + tmf_pkg::SUM_W'(win_reg[tmf_pkg::TRIM_LO+2])
               + tmf_pkg::SUM_W'(win_reg[tmf_pkg::TRIM_LO+3]);
    assign mean = sum[tmf_pkg::SUM_W-1:2];

    assign open_cur  = open_reg[chan_reg];
    assign short_cur = short_reg[chan_reg];

    // open test wins over short test; in range clears both
    always_comb begin
        open_next  = open_cur;
        short_next = short_cur;
        if (mean < open_thr_reg) begin
            open_next = 1'b1;
        end else if (mean >= short_thr_reg) begin
            short_next = 1'b1;
        end else begin
            open_next  = 1'b0;
            short_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) begin
                fill_reg[c]  <= '0;
                open_reg[c]  <= 1'b0;
                short_reg[c] <= 1'b0;
            end
            open_thr_reg  <= tmf_pkg::OPEN_RESET;
            short_thr_reg <= tmf_pkg::SHORT_RESET;
        end else begin
            if (wr_en) begin
                fill_reg[in_idx] <= (wr_pos == tmf_pkg::LAST_POS) ? '0 : wr_pos + 1'b1;
            end
            if (cmd.load_out) begin
                open_reg[chan_reg]  <= open_next;
                short_reg[chan_reg] <= short_next;
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    tmf_pkg::REG_OPEN_THR:  open_thr_reg  <= cfg_wdata;
                    tmf_pkg::REG_SHORT_THR: short_thr_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_chan_reg  <= tmf_pkg::CHAN_W'(chan_reg);
            filt_reg      <= mean;
            out_open_reg  <= open_next;
            out_short_reg <= short_next;
        end
    end

    assign m_tdata = {out_short_reg, out_open_reg, filt_reg, out_chan_reg};

`ifndef SYNTHESIS
    logic win_sorted;
    logic fill_ok;

    always_comb begin
        win_sorted = 1'b1;
        for (int i = 0; i < tmf_pkg::WINDOW - 1; i++) begin
            if (win_reg[i] > win_reg[i+1]) begin
                win_sorted = 1'b0;
            end
        end
        fill_ok = 1'b1;
        for (int c = 0; c < CHANNELS; c++) begin
            if (fill_reg[c] > tmf_pkg::LAST_POS) begin
                fill_ok = 1'b0;
            end
        end
    end

    a_sorted_at_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> win_sorted)
        else $error("window not sorted when result is loaded");

    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_ok)
        else $error("fill count beyond window");

    a_no_write_during_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.capture || cmd.sort_en) |-> !cmd.write_smp)
        else $error("sample written while a window is in progress");
`endif

endmodule

// File: hw/rtl/tmf_ctrl.sv
// Controller: sequences store reads, sort phases and result hand-off.
`timescale 1ns / 1ps

module tmf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  tmf_pkg::tmf_sts_t sts,
    output tmf_pkg::tmf_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_READ   = 2'd1;
    localparam logic [1:0] ST_SORT   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam logic [tmf_pkg::CNT_W-1:0] READ_LAST = tmf_pkg::CNT_W'(tmf_pkg::WINDOW);
    localparam logic [tmf_pkg::CNT_W-1:0] SORT_LAST = tmf_pkg::CNT_W'(tmf_pkg::WINDOW - 1);

    logic [1:0]                state_reg, state_next;
    logic [tmf_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.rd_idx   = cnt_reg;
        cmd.sort_odd = cnt_reg[0];
        s_tready     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready      = 1'b1;
                cmd.write_smp = s_tvalid;
                if (s_tvalid && sts.win_done) begin
                    state_next = ST_READ;
                    cnt_next   = '0;
                end
            end
            ST_READ: begin
                // read data is registered, so it lands in the cycle after its address
                cmd.rd_en   = (cnt_reg != READ_LAST);
                cmd.capture = (cnt_reg != '0);
                if (cnt_reg == READ_LAST) begin
                    state_next = ST_SORT;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SORT: begin
                cmd.sort_en = 1'b1;
                if (cnt_reg == SORT_LAST) begin
                    state_next = ST_FINISH;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

`ifndef SYNTHESIS
    a_load_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("result loaded over a pending beat");

    a_read_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ && $past(state_reg) == ST_IDLE)
            |-> $past(s_tvalid && sts.win_done))
        else $error("window read without a completing beat");

    a_sort_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && $past(state_reg) == ST_SORT)
            |-> $past(cnt_reg) == SORT_LAST)
        else $error("sort left before all phases ran");
`endif

endmodule

// File: tb/sv/trimmed_mean_adc_fault_filter_core_test.sv
// Self-checking testbench for the trimmed-mean ADC fault filter core.
`timescale 1ns / 1ps

module trimmed_mean_adc_fault_filter_core_test;
    import tmf_pkg::*;

    localparam int CHANS         = CHANNELS_DEF;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 100;
    localparam int DIR_ROWS      = 24;
    localparam int SAMPLE_MAX    = (1 << SAMPLE_W) - 1;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;

    typedef struct packed {
        logic [CHAN_W-1:0]   chan;
        logic [SAMPLE_W-1:0] filtered;
        logic                open_f;
        logic                short_f;
    } window_result_t;

    typedef struct packed {
        logic [CHAN_W-1:0]   chan;
        logic [SAMPLE_W-1:0] sample;
        logic                known;
        window_result_t      want;
    } stim_row_t;

    localparam window_result_t NO_WANT = '0;

    // partial windows on ch2/ch3, full-scale window on ch0, zero window on ch1
    stim_row_t dir_rows [DIR_ROWS] = '{
        '{2'd2, 12'hAAA, 1'b0, NO_WANT},
        '{2'd3, 12'h555, 1'b0, NO_WANT},
        '{2'd0, 12'hFFF, 1'b0, NO_WANT}, '{2'd1, 12'h000, 1'b0, NO_WANT},
        '{2'd0, 12'hFFF, 1'b0, NO_WANT}, '{2'd1, 12'h000, 1'b0, NO_WANT},
        '{2'd0, 12'hFFF, 1'b0, NO_WANT}, '{2'd1, 12'h000, 1'b0, NO_WANT},
        '{2'd0, 12'hFFF, 1'b0, NO_WANT}, '{2'd1, 12'h000, 1'b0, NO_WANT},
        '{2'd0, 12'hFFF, 1'b0, NO_WANT}, '{2'd1, 12'h000, 1'b0, NO_WANT},
        '{2'd0, 12'hFFF, 1'b0, NO_WANT}, '{2'd1, 12'h000, 1'b0, NO_WANT},
        '{2'd0, 12'hFFF, 1'b0, NO_WANT}, '{2'd1, 12'h000, 1'b0, NO_WANT},
        '{2'd0, 12'hFFF, 1'b0, NO_WANT}, '{2'd1, 12'h000, 1'b0, NO_WANT},
        '{2'd0, 12'hFFF, 1'b0, NO_WANT}, '{2'd1, 12'h000, 1'b0, NO_WANT},
        '{2'd0, 12'hFFF, 1'b1, '{2'd0, 12'd4095, 1'b0, 1'b1}},
        '{2'd1, 12'h000, 1'b1, '{2'd1, 12'd0, 1'b1, 1'b0}},
        '{2'd2, 12'h555, 1'b0, NO_WANT},
        '{2'd3, 12'hAAA, 1'b0, NO_WANT}
    };

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // channel[1:0], sample[13:2], zero[15:14]
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // out_channel[1:0], filtered[13:2],
                                       // open_fault[14], short_fault[15]
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [SAMPLE_W-1:0]    cfg_wdata;

    // predictor state
    logic [SAMPLE_W-1:0] win_buf [CHANS][WINDOW];
    int unsigned         win_fill [CHANS];
    bit                  open_flag [CHANS];
    bit                  short_flag [CHANS];
    logic [SAMPLE_W-1:0] open_thr;
    logic [SAMPLE_W-1:0] short_thr;
    window_result_t      pending_results [$];

    int  err_count = 0;
    int  cycle_count = 0;
    int  samples_sent = 0;
    int  windows_seen = 0;
    int  open_seen = 0;
    int  short_seen = 0;
    int  settings_used = 1;
    int  burst_left = 0;
    int  chan_level [CHANS];
    int  chan_spread [CHANS];
    logic [6:0] rx_phase = '0;
    logic [1:0] rx_mode = '0;

    trimmed_mean_adc_fault_filter_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d windows still pending", $time, pending_results.size());
            $display("FAIL trimmed_mean_adc_fault_filter_core");
            $finish;
        end
    end

    function automatic logic [SAMPLE_W-1:0] trimmed_mean(int ch);
        logic [SAMPLE_W-1:0] v [WINDOW];
        logic [SAMPLE_W-1:0] t;
        logic [SUM_W-1:0]    sum;
        for (int i = 0; i < WINDOW; i++) v[i] = win_buf[ch][i];
        for (int a = 0; a < WINDOW; a++) begin
            for (int b = a + 1; b < WINDOW; b++) begin
                if (v[a] > v[b]) begin
                    t = v[a];
                    v[a] = v[b];
                    v[b] = t;
                end
            end
        end
        sum = '0;
        for (int i = TRIM_LO; i < TRIM_LO + 4; i++) sum += SUM_W'(v[i]);
        return sum[SUM_W-1:2];
    endfunction

    // appends one sample; returns 1 with the window result when the window closes
    function automatic bit filter_sample(int ch, logic [SAMPLE_W-1:0] smp,
                                         output window_result_t res);
        int unsigned         pos;
        logic [SAMPLE_W-1:0] val;
        res = NO_WANT;
        if (ch >= CHANS) return 1'b0;
        pos = win_fill[ch];
        if (pos >= WINDOW) pos = 0;
        win_buf[ch][pos] = smp;
        pos++;
        if (pos < WINDOW) begin
            win_fill[ch] = pos;
            return 1'b0;
        end
        win_fill[ch] = 0;
        val = trimmed_mean(ch);
        if (val < open_thr) begin
            open_flag[ch] = 1'b1;
        end else if (val >= short_thr) begin
            short_flag[ch] = 1'b1;
        end else begin
            open_flag[ch] = 1'b0;
            short_flag[ch] = 1'b0;
        end
        res = '{CHAN_W'(ch), val, open_flag[ch], short_flag[ch]};
        return 1'b1;
    endfunction

    function automatic void check_field(string what, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            err_count++;
        end
    endfunction

    task automatic send_sample(input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] smp,
                               input logic known, input window_result_t want);
        window_result_t res;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, smp, ch};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        samples_sent++;
        if (filter_sample(ch, smp, res)) pending_results.push_back(known ? want : res);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
    endtask

    task automatic drain_results();
        idle_cycles(1);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_OPEN_THR:  open_thr = data;
            REG_SHORT_THR: short_thr = data;
            default: ;
        endcase
    endtask

    // receiver: always ready, coin flip, mostly stalled, or stalled while rx_phase[5:4] is 2'b11
    always @(negedge aclk) begin
        rx_phase <= rx_phase + 1'b1;
        if (rx_phase == '0) rx_mode <= 2'($urandom_range(0, 3));
        case (rx_mode)
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= 1'($urandom_range(0, 1));
            2'd2:    m_tready <= ($urandom_range(0, 7) == 0);
            default: m_tready <= (rx_phase[5:4] != 2'b11);
        endcase
    end

    always @(posedge aclk) begin
        window_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with no window pending, expected none, got tdata=%h",
                         $time, m_tdata);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("out_channel", want.chan, m_tdata[1:0]);
                check_field("filtered", want.filtered, m_tdata[13:2]);
                check_field("open_fault", want.open_f, m_tdata[14]);
                check_field("short_fault", want.short_f, m_tdata[15]);
                windows_seen++;
                if (m_tdata[14]) open_seen++;
                if (m_tdata[15]) short_seen++;
            end
        end
    end

    initial begin
        int                  ch;
        int                  v;
        int                  o_set;
        int                  s_set;
        bit                  no_idle;
        logic [SAMPLE_W-1:0] smp;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        open_thr  = OPEN_RESET;
        short_thr = SHORT_RESET;
        for (int c = 0; c < CHANS; c++) begin
            win_fill[c]   = 0;
            open_flag[c]  = 1'b0;
            short_flag[c] = 1'b0;
            for (int i = 0; i < WINDOW; i++) win_buf[c][i] = '0;
        end

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
            send_sample(dir_rows[r].chan, dir_rows[r].sample, dir_rows[r].known,
                        dir_rows[r].want);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                drain_results();
                case (ph)
                    1: begin o_set = 0;    s_set = SAMPLE_MAX; end
                    2: begin o_set = SAMPLE_MAX; s_set = 0;    end  // overlapping
                    3: begin o_set = 2048; s_set = 2048; end
                    4: begin o_set = 1;    s_set = SAMPLE_MAX - 1; end
                    default: begin
                        o_set = $urandom_range(0, 2048);
                        s_set = $urandom_range(1024, SAMPLE_MAX);
                    end
                endcase
                write_reg(REG_SPARE2, 12'($urandom_range(0, SAMPLE_MAX)));
                write_reg(REG_OPEN_THR, 12'(o_set));
                write_reg(REG_SHORT_THR, 12'(s_set));
                write_reg(REG_SPARE3, 12'($urandom_range(0, SAMPLE_MAX)));
                settings_used++;
            end
            no_idle = (ph % 3 == 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 3 && n == PHASE_ITEMS / 2) drain_results();
                if (!no_idle && burst_left <= 0) begin
                    idle_cycles($urandom_range(1, 20));
                    burst_left = $urandom_range(1, 30);
                end
                burst_left--;
                ch = $urandom_range(0, CHANS - 1);
                if (win_fill[ch] == 0) begin
                    case ($urandom_range(0, 5))
                        0:       chan_level[ch] = open_thr;
                        1:       chan_level[ch] = short_thr;
                        2:       chan_level[ch] = 0;
                        3:       chan_level[ch] = SAMPLE_MAX;
                        default: chan_level[ch] = $urandom_range(0, SAMPLE_MAX);
                    endcase
                    chan_spread[ch] = $urandom_range(0, 1) ? 0 : $urandom_range(1, 24);
                end
                if ($urandom_range(0, 9) == 0) begin
                    smp = 12'($urandom_range(0, SAMPLE_MAX));
                end else begin
                    v = chan_level[ch] + int'($urandom_range(0, 2 * chan_spread[ch]))
                        - chan_spread[ch];
                    if (v < 0) v = 0;
                    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
                    smp = 12'(v);
                end
                send_sample(CHAN_W'(ch), smp, 1'b0, NO_WANT);
            end
        end

        drain_results();

        $display("Sent %0d samples over %0d threshold settings, incl. overlapping thresholds",
                 samples_sent, settings_used);
        $display("Checked %0d window results: %0d with open flag, %0d with short flag",
                 windows_seen, open_seen, short_seen);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("PASS trimmed_mean_adc_fault_filter_core");
        end else begin
            $display("FAIL trimmed_mean_adc_fault_filter_core");
        end
        $finish;
    end

endmodule

// File: trimmed_mean_adc_fault_filter_core.f
hw/rtl/tmf_pkg.sv
hw/rtl/tmf_ram.sv
hw/rtl/tmf_datapath.sv
hw/rtl/tmf_ctrl.sv
hw/rtl/trimmed_mean_adc_fault_filter_core.sv
tb/sv/trimmed_mean_adc_fault_filter_core_test.sv
